### rtl/mlfq_pkg.sv
package mlfq_pkg;

   localparam int MaxProcs  = 32;
   localparam int IdBits    = 16;
   localparam int SlotBits  = $clog2(MaxProcs);
   localparam int CountBits = $clog2(MaxProcs + 1);

   localparam logic [31:0] QuantumHighReset = 32'd10000000;
   localparam logic [31:0] QuantumMidReset  = 32'd20000000;
   localparam logic [31:0] QuantumLowReset  = 32'd40000000;
   localparam logic [7:0]  BlockSecReset    = 8'd1;
   localparam logic [5:0]  MaxActiveReset   = 6'd32;

   typedef enum logic [1:0] {
      MODE_ADMIT  = 2'd0,
      MODE_SELECT = 2'd1,
      MODE_REPORT = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OUT_TERM    = 2'd0,
      OUT_FULL_Q  = 2'd1,
      OUT_BLOCKED = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NONE     = 3'd1,
      ST_LIMIT    = 3'd2,
      ST_NOT_HEAD = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_QHIGH  = 3'd0,
      CSR_QMID   = 3'd1,
      CSR_QLOW   = 3'd2,
      CSR_BLOCK  = 3'd3,
      CSR_MAXACT = 3'd4
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FRONT,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DONE
   } state_type;

endpackage

### rtl/multilevel_feedback_scheduler_top.sv
// Three-level feedback scheduler with a blocked list.
// Command channel: req_* fields are taken at a clock edge where start is
// high and busy is low; busy stays high until the cycle the result is shown.
// Result channel: rsp_valid is high for exactly one cycle with rsp_status
// and the other rsp_* fields; the receiver cannot stall it.
// Config channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready
// is always high. Write only while busy is low.
// Sequence: admit, select and report pass a front read state and a decision
// state, then show the result, and the next command can be taken at the edge
// that ends the result cycle, so a new command waits until the last result is
// shown. A tick walks the 32 blocked slots with a read state and a compare
// state for each, then a closing state, and then shows its result; no new
// command is taken until the tick's result is shown.
// Reset clears the queue pointers, blocked valid bits, active count and
// the configuration registers to their defaults. The ready queues and the
// blocked memories themselves are not cleared; only written entries are read.
module multilevel_feedback_scheduler_top
   import mlfq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_proc_id,
   input  logic [1:0]  req_outcome,
   input  logic [31:0] req_now_sec,
   input  logic [29:0] req_now_ns,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_chosen_id,
   output logic [1:0]  rsp_chosen_level,
   output logic [31:0] rsp_slice_ns,
   output logic [5:0]  rsp_released_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration
   logic [31:0] qhigh_ff, qmid_ff, qlow_ff;
   logic [7:0]  blksec_ff;
   logic [5:0]  maxact_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qhigh_ff  <= QuantumHighReset;
         qmid_ff   <= QuantumMidReset;
         qlow_ff   <= QuantumLowReset;
         blksec_ff <= BlockSecReset;
         maxact_ff <= MaxActiveReset;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_QHIGH:  qhigh_ff  <= csr_data;
            CSR_QMID:   qmid_ff   <= csr_data;
            CSR_QLOW:   qlow_ff   <= csr_data;
            CSR_BLOCK:  blksec_ff <= csr_data[7:0];
            CSR_MAXACT: maxact_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // memories
   logic [IdBits-1:0] qmem_top [MaxProcs];
   logic [IdBits-1:0] qmem_mid [MaxProcs];
   logic [IdBits-1:0] qmem_low [MaxProcs];
   logic [IdBits-1:0] bmem_id  [MaxProcs];
   logic [31:0]       bmem_sec [MaxProcs];
   logic [29:0]       bmem_ns  [MaxProcs];

   // queue pointers and control state
   logic [SlotBits-1:0]  head_ff [3];
   logic [SlotBits-1:0]  tail_ff [3];
   logic [CountBits-1:0] cnt_ff  [3];
   logic [MaxProcs-1:0]  bvalid_ff;
   logic [5:0]           active_ff;
   state_type            state_ff, state_in;

   // latched command
   logic [1:0]        mode_ff;
   logic [IdBits-1:0] id_ff;
   logic [1:0]        outc_ff;
   logic [31:0]       nsec_ff;
   logic [29:0]       nns_ff;

   // registered memory reads
   logic [IdBits-1:0] front_ff [3];
   logic [IdBits-1:0] rd_id_ff;
   logic [31:0]       rd_sec_ff;
   logic [29:0]       rd_ns_ff;

   logic [SlotBits:0] scan_ff;
   logic [5:0]        rel_ff;

   // output registers
   logic        rv_ff;
   logic [2:0]  rst_ff;
   logic [15:0] rid_ff;
   logic [1:0]  rlev_ff;
   logic [31:0] rsl_ff;

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_chosen_id      = rid_ff;
   assign rsp_chosen_level   = rlev_ff;
   assign rsp_slice_ns       = rsl_ff;
   assign rsp_released_count = rel_ff;

   // decision logic
   logic [1:0] found;
   logic       hit;
   logic       free_any;
   logic [SlotBits-1:0] free_slot;
   logic [32:0] until_sum;
   logic [31:0] until_sec;
   logic        due;
   logic        full_top;

   always_comb begin
      hit   = 1'b0;
      found = 2'd0;
      for (int lv = 2; lv >= 0; lv--) begin
         if (cnt_ff[lv] != '0 && front_ff[lv] == id_ff) begin
            hit   = 1'b1;
            found = 2'(lv);
         end
      end
      free_any  = 1'b0;
      free_slot = '0;
      for (int k = MaxProcs - 1; k >= 0; k--) begin
         if (!bvalid_ff[k]) begin
            free_any  = 1'b1;
            free_slot = SlotBits'(k);
         end
      end
      until_sum = {1'b0, nsec_ff} + {25'd0, blksec_ff};
      until_sec = until_sum[32] ? 32'hFFFF_FFFF : until_sum[31:0];
      due = (nsec_ff > rd_sec_ff) || (nsec_ff == rd_sec_ff && nns_ff >= rd_ns_ff);
      full_top = (cnt_ff[0] >= CountBits'(MaxProcs));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (start) state_in = (mode_type'(req_mode) == MODE_TICK)
                                          ? S_SCAN_RD : S_FRONT;
         S_FRONT:    state_in = S_DECIDE;
         S_DECIDE:   state_in = S_IDLE;
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: state_in = (scan_ff == (SlotBits+1)'(MaxProcs - 1))
                                ? S_DONE : S_SCAN_RD;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // memory reads, registered
   always_ff @(posedge clock) begin
      front_ff[0] <= qmem_top[head_ff[0]];
      front_ff[1] <= qmem_mid[head_ff[1]];
      front_ff[2] <= qmem_low[head_ff[2]];
      rd_id_ff    <= bmem_id [scan_ff[SlotBits-1:0]];
      rd_sec_ff   <= bmem_sec[scan_ff[SlotBits-1:0]];
      rd_ns_ff    <= bmem_ns [scan_ff[SlotBits-1:0]];
   end

   // queue writes: one push per cycle, to a single level
   logic              push_en;
   logic [1:0]        push_lv;
   logic [IdBits-1:0] push_id;
   logic              pop_en;
   logic [1:0]        pop_lv;
   logic              bwr_en;

   always_comb begin
      push_en = 1'b0; push_lv = 2'd0; push_id = id_ff;
      pop_en  = 1'b0; pop_lv  = found;
      bwr_en  = 1'b0;
      if (state_ff == S_DECIDE) begin
         case (mode_type'(mode_ff))
            MODE_ADMIT:
               if (active_ff < maxact_ff && !full_top) push_en = 1'b1;
            MODE_REPORT:
               if (hit) begin
                  case (outcome_type'(outc_ff))
                     OUT_TERM: pop_en = 1'b1;
                     OUT_FULL_Q:
                        if (found == 2'd2) begin
                           pop_en = 1'b1; push_en = 1'b1; push_lv = 2'd2;
                        end else if (cnt_ff[found + 2'd1] < CountBits'(MaxProcs)) begin
                           pop_en = 1'b1; push_en = 1'b1; push_lv = found + 2'd1;
                        end
                     OUT_BLOCKED:
                        if (free_any) begin
                           pop_en = 1'b1; bwr_en = 1'b1;
                        end
                     default: ;
                  endcase
               end
            default: ;
         endcase
      end else if (state_ff == S_SCAN_CHK) begin
         if (bvalid_ff[scan_ff[SlotBits-1:0]] && due && !full_top) begin
            push_en = 1'b1; push_id = rd_id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         case (push_lv)
            2'd0:    qmem_top[tail_ff[0]] <= push_id;
            2'd1:    qmem_mid[tail_ff[1]] <= push_id;
            default: qmem_low[tail_ff[2]] <= push_id;
         endcase
      end
      if (bwr_en) begin
         bmem_id [free_slot] <= id_ff;
         bmem_sec[free_slot] <= until_sec;
         bmem_ns [free_slot] <= nns_ff;
      end
   end

   // pointers, valid bits, counters, results
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < 3; lv++) begin
            head_ff[lv] <= '0; tail_ff[lv] <= '0; cnt_ff[lv] <= '0;
         end
         bvalid_ff <= '0;
         active_ff <= '0;
         rv_ff     <= 1'b0;
         scan_ff   <= '0;
         rel_ff    <= '0;
      end else begin
         rv_ff <= 1'b0;
         if (pop_en) begin
            head_ff[pop_lv] <= head_ff[pop_lv] + 1'b1;
         end
         if (push_en) begin
            tail_ff[push_lv] <= tail_ff[push_lv] + 1'b1;
         end
         for (int lv = 0; lv < 3; lv++) begin
            if ((push_en && push_lv == 2'(lv)) && !(pop_en && pop_lv == 2'(lv)))
               cnt_ff[lv] <= cnt_ff[lv] + 1'b1;
            else if (!(push_en && push_lv == 2'(lv)) && (pop_en && pop_lv == 2'(lv)))
               cnt_ff[lv] <= cnt_ff[lv] - 1'b1;
         end
         if (bwr_en) bvalid_ff[free_slot] <= 1'b1;

         case (state_ff)
            S_IDLE:
               if (start) begin
                  mode_ff <= req_mode;
                  id_ff   <= req_proc_id;
                  outc_ff <= req_outcome;
                  nsec_ff <= req_now_sec;
                  nns_ff  <= req_now_ns;
                  scan_ff <= '0;
                  rel_ff  <= '0;
               end
            S_DECIDE: begin
               rv_ff   <= 1'b1;
               rst_ff  <= ST_OK;
               rid_ff  <= '0;
               rlev_ff <= '0;
               rsl_ff  <= '0;
               rel_ff  <= '0;
               case (mode_type'(mode_ff))
                  MODE_ADMIT:
                     if (active_ff >= maxact_ff) rst_ff <= ST_LIMIT;
                     else if (full_top)          rst_ff <= ST_FULL;
                     else                        active_ff <= active_ff + 6'd1;
                  MODE_SELECT:
                     if (cnt_ff[0] != '0) begin
                        rid_ff <= front_ff[0]; rlev_ff <= 2'd0; rsl_ff <= qhigh_ff;
                     end else if (cnt_ff[1] != '0) begin
                        rid_ff <= front_ff[1]; rlev_ff <= 2'd1; rsl_ff <= qmid_ff;
                     end else if (cnt_ff[2] != '0) begin
                        rid_ff <= front_ff[2]; rlev_ff <= 2'd2; rsl_ff <= qlow_ff;
                     end else begin
                        rst_ff <= ST_NONE;
                     end
                  MODE_REPORT:
                     if (!hit) rst_ff <= ST_NOT_HEAD;
                     else begin
                        case (outcome_type'(outc_ff))
                           OUT_TERM:
                              if (active_ff != '0) active_ff <= active_ff - 6'd1;
                           OUT_FULL_Q:
                              if (found != 2'd2 &&
                                  cnt_ff[found + 2'd1] >= CountBits'(MaxProcs))
                                 rst_ff <= ST_FULL;
                           OUT_BLOCKED:
                              if (!free_any) rst_ff <= ST_FULL;
                           default: ;
                        endcase
                     end
                  default: ;
               endcase
            end
            S_SCAN_CHK: begin
               if (push_en) begin
                  bvalid_ff[scan_ff[SlotBits-1:0]] <= 1'b0;
                  if (rel_ff != 6'd63) rel_ff <= rel_ff + 6'd1;
               end
               scan_ff <= scan_ff + 1'b1;
            end
            S_DONE: begin
               rv_ff   <= 1'b1;
               rst_ff  <= ST_OK;
               rid_ff  <= '0;
               rlev_ff <= '0;
               rsl_ff  <= '0;
            end
            default: ;
         endcase
      end
   end

endmodule
